@@ hw/rtl/softmax_normalizer_defines.svh @@
// assertion macros for the softmax normaliser
`ifndef SOFTMAX_NORMALIZER_DEFINES_SVH
`define SOFTMAX_NORMALIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define SMX_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SMX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SMX_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SMX_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/smx_pkg.sv @@
// shared types, constants and functions for the softmax normaliser
package smx_pkg;
    localparam int MaxRows = 64;
    localparam int IdxW = $clog2(MaxRows);
    localparam int CntW = $clog2(MaxRows + 1);
    localparam int SumW = 23;

    typedef struct packed {
        logic load;
        logic clear;
        logic sum_start;
        logic sum_acc;
        logic emit_start;
        logic div_start;
        logic out_load;
    } smx_cmd_t;

    typedef struct packed {
        logic div_done;
        logic last_idx;
        logic out_free;
    } smx_sts_t;

    // 2^(-j/16) in 1.16
    function automatic logic [16:0] pow2_lut(input logic [3:0] j);
        logic [16:0] v;
        unique case (j)
            4'd0: v = 17'd65536;   4'd1: v = 17'd62757;
            4'd2: v = 17'd60097;   4'd3: v = 17'd57549;
            4'd4: v = 17'd55109;   4'd5: v = 17'd52773;
            4'd6: v = 17'd50535;   4'd7: v = 17'd48393;
            4'd8: v = 17'd46341;   4'd9: v = 17'd44376;
            4'd10: v = 17'd42495;  4'd11: v = 17'd40693;
            4'd12: v = 17'd38968;  4'd13: v = 17'd37316;
            4'd14: v = 17'd35734;  default: v = 17'd34219;
        endcase
        return v;
    endfunction
endpackage

@@ hw/rtl/smx_ctrl.sv @@
// controller state machine for the softmax normaliser
module smx_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic              in_last,
    input  smx_pkg::smx_sts_t sts,
    output logic              in_ready,
    output smx_pkg::smx_cmd_t cmd
);
    localparam logic [2:0] StLoad = 3'd0;
    localparam logic [2:0] StRead = 3'd1;
    localparam logic [2:0] StSum  = 3'd2;
    localparam logic [2:0] StEmit = 3'd3;
    localparam logic [2:0] StDiv  = 3'd4;
    localparam logic [2:0] StOut  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= StLoad;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequencing: load, sum pass, then divide and emit per entry
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            StLoad: begin
                in_ready = 1'b1;
                cmd.load = in_fire;
                if (in_fire && in_last) begin
                    state_next = StRead;
                end
            end
            StRead: begin
                // store is settled, read entry zero
                cmd.sum_start = 1'b1;
                state_next    = StSum;
            end
            StSum: begin
                cmd.sum_acc = 1'b1;
                if (sts.last_idx) begin
                    state_next     = StEmit;
                    cmd.emit_start = 1'b1;
                end
            end
            StEmit: begin
                cmd.div_start = 1'b1;
                state_next    = StDiv;
            end
            StDiv: begin
                if (sts.div_done) begin
                    state_next = StOut;
                end
            end
            StOut: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.last_idx) begin
                        cmd.clear  = 1'b1;
                        state_next = StLoad;
                    end else begin
                        state_next = StEmit;
                    end
                end
            end
            default: state_next = StLoad;
        endcase
    end
endmodule

@@ hw/rtl/smx_datapath.sv @@
// sample store, exponential, sum and restoring divider
module smx_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  smx_pkg::smx_cmd_t cmd,
    input  logic [15:0]       in_sample,
    output smx_pkg::smx_sts_t sts,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_prob,
    output logic              m_last,
    output logic              m_ovf
);
    localparam int IW = smx_pkg::IdxW;
    localparam int CW = smx_pkg::CntW;
    localparam int SW = smx_pkg::SumW;

    logic [15:0]   mem [smx_pkg::MaxRows];
    logic [15:0]   rd_reg;
    logic [IW-1:0] rd_addr;
    logic signed [15:0] max_reg;
    logic [CW-1:0] cnt_reg;
    logic [IW-1:0] ptr_reg;
    logic          ovf_reg;
    logic [SW-1:0] sum_reg;
    logic [24:0]   d_mul;
    logic [16:0]   t;
    logic [16:0]   e_comb;
    logic [15:0]   d;
    logic          full;

    // divider state
    logic [32:0] rem_reg;
    logic [32:0] quo_reg;
    logic [5:0]  it_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [33:0] trial;

    logic        ov_reg;
    logic [15:0] prob_reg;
    logic        last_reg, ovf_out_reg;

    assign full = (cnt_reg == CW'(smx_pkg::MaxRows));

    // store write and registered read
    assign rd_addr = cmd.sum_start ? '0 : (cmd.emit_start ? '0 : ptr_reg);
    always_ff @(posedge aclk) begin
        if (cmd.load && !full) begin
            mem[cnt_reg[IW-1:0]] <= in_sample;
        end
        rd_reg <= mem[rd_addr];
    end

    // exponential of the difference from the maximum
    assign d     = 16'($signed({max_reg[15], max_reg}) - $signed({rd_reg[15], rd_reg}));
    assign d_mul = 25'(d) * 25'd369 + 25'd128;
    assign t     = d_mul[24:8];
    always_comb begin
        if (t[16:8] >= 9'd17) begin
            e_comb = '0;
        end else begin
            e_comb = smx_pkg::pow2_lut(t[7:4]) >> t[12:8];
        end
    end

    // column state and entry pointer
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            max_reg <= 16'sh8000;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            ptr_reg <= '0;
            sum_reg <= '0;
        end else begin
            if (cmd.load) begin
                if (full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if ($signed(in_sample) > max_reg) begin
                        max_reg <= in_sample;
                    end
                end
            end
            if (cmd.sum_start || cmd.emit_start) begin
                ptr_reg <= IW'(1);
            end else if (cmd.sum_acc || cmd.out_load) begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (cmd.sum_start) begin
                sum_reg <= '0;
            end else if (cmd.sum_acc) begin
                sum_reg <= sum_reg + SW'(e_comb);
            end
        end
    end

    // entry index of the value being summed, or of the entry being divided and emitted
    logic [IW-1:0] cur_idx_reg;
    always_ff @(posedge aclk) begin
        if (cmd.sum_start || cmd.emit_start) begin
            cur_idx_reg <= '0;
        end else if (cmd.sum_acc) begin
            cur_idx_reg <= cur_idx_reg + 1'b1;
        end else if (cmd.out_load) begin
            cur_idx_reg <= cur_idx_reg + 1'b1;
        end
    end
    assign sts.last_idx = ({1'b0, cur_idx_reg} + 1'b1) == CW'(cnt_reg);

    // restoring division of e<<16 by the sum, one bit a cycle
    assign trial = {rem_reg, quo_reg[32]} - {11'd0, sum_reg};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (cmd.div_start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            rem_reg  <= '0;
            quo_reg  <= {e_comb, 16'd0};
            it_reg   <= 6'd33;
        end else if (busy_reg) begin
            if (trial[33]) begin
                rem_reg <= {rem_reg[31:0], quo_reg[32]};
                quo_reg <= {quo_reg[31:0], 1'b0};
            end else begin
                rem_reg <= trial[32:0];
                quo_reg <= {quo_reg[31:0], 1'b1};
            end
            it_reg <= it_reg - 1'b1;
            if (it_reg == 6'd1) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else if (cmd.out_load) begin
            done_reg <= 1'b0;
        end
    end
    assign sts.div_done = done_reg;

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (cmd.out_load) begin
            ov_reg <= 1'b1;
        end else if (m_tready) begin
            ov_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            if (sum_reg == '0) begin
                prob_reg <= '0;
            end else if (quo_reg[32:16] != '0) begin
                prob_reg <= 16'hFFFF;
            end else begin
                prob_reg <= quo_reg[15:0];
            end
            last_reg    <= sts.last_idx;
            ovf_out_reg <= ovf_reg;
        end
    end
    assign sts.out_free = !ov_reg || m_tready;
    assign m_tvalid = ov_reg;
    assign m_prob   = prob_reg;
    assign m_last   = last_reg;
    assign m_ovf    = ovf_out_reg;
endmodule

@@ hw/rtl/softmax_normalizer.sv @@
// softmax normaliser top level: stream ports, controller and datapath
// sequence after the closing word (n stored samples): a read of entry zero, a sum pass
//   over the stored samples, then per entry a divide and an output load
// throughput: one input word per cycle while loading; results come one at a time from
//   the bit-serial divider of 33 steps, the next divide starting after the output load
// reset: aresetn synchronous active low, clears controller, column and divider state and the output valid flag
`include "softmax_normalizer_defines.svh"
module softmax_normalizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample_value
    input  logic        s_tlast,   // last_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // probability
    output logic        m_tlast,   // last_result
    output logic        m_tuser    // overflow
);
    smx_pkg::smx_cmd_t cmd;
    smx_pkg::smx_sts_t sts;
    logic              in_fire;

    assign in_fire = s_tvalid && s_tready;

    smx_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_last  (s_tlast),
        .sts      (sts),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    smx_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_sample (s_tdata),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_prob    (m_tdata),
        .m_last    (m_tlast),
        .m_ovf     (m_tuser)
    );

    // checks
    `SMX_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `SMX_ASSERT_IMPL(a_no_in_while_out, aclk, aresetn, cmd.out_load, !s_tready)
    `SMX_ASSERT_IMPL(a_load_only_ready, aclk, aresetn, cmd.load, s_tready)
endmodule

@@ tb/softmax_normalizer_tb.sv @@
// testbench for the softmax normaliser: stream stimulus, built-in predictor and result checker
`timescale 1ns / 1ps

module softmax_normalizer_tb;

    // expected result word
    typedef struct packed {
        logic [15:0] prob;
        logic        last;
        logic        ovf;
    } share_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // sample_value
    logic        s_tlast;   // last_sample
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // probability
    logic        m_tlast;   // last_result
    logic        m_tuser;   // overflow

    // predictor state for the open column
    logic signed [15:0] col_samples [smx_pkg::MaxRows];
    logic signed [15:0] col_max;
    int                 col_count;
    logic               col_ovf;

    share_t expected_shares[$];
    int     errors;
    int     cycles;
    int     hold_off;
    logic   rx_pause;

    softmax_normalizer dut (.*);

    // clock
    always begin
        aclk = 1'b1; #1;
        aclk = 1'b0; #1;
    end

    // fixed point exp(-d) from the 2^(-j/16) table and a shift
    function automatic logic [16:0] exp_of_gap(input logic [15:0] gap);
        logic [31:0] t;
        logic [31:0] whole;
        logic [16:0] mant;
        t = (32'(gap) * 32'd369 + 32'd128) >> 8;
        whole = t >> 8;
        case (t[7:4])
            4'd0: mant = 17'd65536;   4'd1: mant = 17'd62757;
            4'd2: mant = 17'd60097;   4'd3: mant = 17'd57549;
            4'd4: mant = 17'd55109;   4'd5: mant = 17'd52773;
            4'd6: mant = 17'd50535;   4'd7: mant = 17'd48393;
            4'd8: mant = 17'd46341;   4'd9: mant = 17'd44376;
            4'd10: mant = 17'd42495;  4'd11: mant = 17'd40693;
            4'd12: mant = 17'd38968;  4'd13: mant = 17'd37316;
            4'd14: mant = 17'd35734;  default: mant = 17'd34219;
        endcase
        if (whole >= 17)
            return 17'd0;
        return mant >> whole;
    endfunction

    // fold one accepted word into the column, predict shares on close
    task automatic predict_column_word(input logic [15:0] value, input logic closes);
        logic [22:0] total;
        logic [16:0] e;
        logic [63:0] p;
        share_t      w;
        if (col_count < smx_pkg::MaxRows) begin
            col_samples[col_count] = value;
            if ($signed(value) > col_max)
                col_max = value;
            col_count++;
        end else begin
            col_ovf = 1'b1;
        end
        if (!closes)
            return;
        total = '0;
        for (int k = 0; k < col_count; k++)
            total += 23'(exp_of_gap(16'(col_max - col_samples[k])));
        for (int k = 0; k < col_count; k++) begin
            e = exp_of_gap(16'(col_max - col_samples[k]));
            p = 0;
            if (total != 0) begin
                p = (64'(e) << 16) / 64'(total);
                if (p > 65535)
                    p = 65535;
            end
            w.prob = p[15:0];
            w.last = (k + 1 == col_count);
            w.ovf  = col_ovf;
            expected_shares.push_back(w);
        end
        col_max = 16'sh8000;
        col_count = 0;
        col_ovf = 1'b0;
    endtask

    // offer one word, wait for acceptance, then an optional gap
    task automatic send_sample(input logic [15:0] value, input logic closes);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= closes;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_column_word(value, closes);
        @(negedge aclk);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic close_idle();
        s_tvalid <= 1'b0;
        while (expected_shares.size() != 0) @(negedge aclk);
    endtask

    // random column of given length, values near each other or spread
    task automatic send_random_column(input int len);
        logic [15:0] base;
        logic [15:0] v;
        base = 16'($urandom);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 2) == 0)
                v = 16'($urandom);
            else
                v = base + 16'($urandom_range(0, 2047)) - 16'd1024;
            send_sample(v, i == len - 1);
        end
    endtask

    // field extremes, single-sample column, equal samples, far gaps
    task automatic test_directed();
        send_sample(16'h7fff, 1'b1);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'h0100, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hff00, 1'b0);
        send_sample(16'h0a00, 1'b1);
        send_sample(16'h5555, 1'b0);
        send_sample(16'haaaa, 1'b0);
        send_sample(16'hffff, 1'b1);
        close_idle();
    endtask

    // more than MaxRows samples, closing word dropped too
    task automatic test_overflow();
        for (int i = 0; i < smx_pkg::MaxRows + 3; i++)
            send_sample(16'($urandom_range(0, 4095)), i == smx_pkg::MaxRows + 2);
        close_idle();
    endtask

    // receiver stalls long while the sender keeps offering
    task automatic test_backpressure();
        hold_off = 400;
        send_random_column(8);
        send_random_column(6);
        close_idle();
    endtask

    // random columns, mostly short
    task automatic test_random_columns();
        int sent;
        int len;
        sent = 0;
        while (sent < 180) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, smx_pkg::MaxRows)
                                                : $urandom_range(1, 8);
            send_random_column(len);
            sent += len;
        end
        close_idle();
    endtask

    // receiver ready pattern with its own long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (rx_pause) begin
            m_tready <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                rx_pause <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 40) == 0)
                rx_pause <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        share_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_shares.size() == 0) begin
                $display("%0t: unexpected word prob=%0d last=%0b ovf=%0b",
                         $time, m_tdata, m_tlast, m_tuser);
                errors++;
            end else begin
                w = expected_shares.pop_front();
                if (w.prob !== m_tdata || w.last !== m_tlast || w.ovf !== m_tuser) begin
                    $display("%0t: mismatch expected prob=%0d last=%0b ovf=%0b, got %0d %0b %0b",
                             $time, w.prob, w.last, w.ovf, m_tdata, m_tlast, m_tuser);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > 600000) begin
            $display("** softmax_normalizer: FAILED **");
            $finish;
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        hold_off = 0;
        rx_pause = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        col_max = 16'sh8000;
        col_count = 0;
        col_ovf = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_overflow();
        test_backpressure();
        test_random_columns();
        repeat (100) @(negedge aclk);
        if (errors == 0 && expected_shares.size() == 0)
            $display("** softmax_normalizer: PASSED **");
        else
            $display("** softmax_normalizer: FAILED **");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/smx_pkg.sv
hw/rtl/smx_ctrl.sv
hw/rtl/smx_datapath.sv
hw/rtl/softmax_normalizer.sv
tb/softmax_normalizer_tb.sv
